@@ design/i2cmts_pkg.sv @@
package i2cmts_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_STATUS  = 2'd2,
        CMD_POLL    = 2'd3
    } cmd_t;

    // Transfer phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2
    } phase_t;

    // Bus actions
    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_START      = 2'd1;
    localparam logic [1:0] ACT_STOP       = 2'd2;
    localparam logic [1:0] ACT_STOP_START = 2'd3;

    // Bus engine status codes
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    localparam logic [7:0] TIMEOUT_RESET = 8'd255;

    // Result word
    typedef struct packed {
        logic       accepted;
        logic [1:0] bus_action;
        logic       send_ack;
        logic       irq_enable;
        logic       transmit_valid;
        logic [7:0] transmit_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       transfer_done;
        logic       transfer_error;
        logic [7:0] error_status;
        logic       busy_res;
    } result_t;

endpackage

@@ design/i2cmts_out_buf.sv @@
module i2cmts_out_buf
    import i2cmts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    // Two-entry skid: main output register plus one spare
    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_word_reg;
    result_t skid_word_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!main_valid_reg || out_ready) begin
                if (skid_valid_reg) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= in_valid;
                end else begin
                    main_valid_reg <= in_valid;
                end
            end else if (in_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_word_reg <= skid_word_reg;
                skid_word_reg <= in_word;
            end else begin
                main_word_reg <= in_word;
            end
        end else if (in_valid) begin
            skid_word_reg <= in_word;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !out_ready) |-> !in_valid)
        else $error("skid overrun");
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid without main");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("output word changed while stalled");
`endif

endmodule

@@ design/i2c_master_transfer_sequencer.sv @@
// An accepted word is registered in stage one and its result word in the output buffer.
// One input word per cycle while the output buffer has room; the write store memory read is
// issued as the word enters stage one and the result is computed in stage two, with forwarding.
// Reset (aresetn, synchronous, active low): queue and store empty, idle, timeout 255;
// no clearing pass, so words may be taken from the first cycle after reset.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int QUEUE_DEPTH       = 4,
    parameter int WRITE_STORE_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_write_length,
    input  logic [7:0] s_read_length,
    input  logic [7:0] s_bus_status,
    input  logic [7:0] s_received_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted,
    output logic [1:0] m_bus_action,
    output logic       m_send_ack,
    output logic       m_irq_enable,
    output logic       m_transmit_valid,
    output logic [7:0] m_transmit_byte,
    output logic       m_read_valid,
    output logic [7:0] m_read_byte,
    output logic       m_transfer_done,
    output logic       m_transfer_error,
    output logic [7:0] m_error_status,
    output logic       m_busy_res
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (WRITE_STORE_DEPTH > 1) ? $clog2(WRITE_STORE_DEPTH) : 1;
    localparam int SC = $clog2(WRITE_STORE_DEPTH + 1);

    // Stage one: capture input; stage two: execute with memory data
    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_data_reg, s1_wl_reg, s1_rl_reg, s1_st_reg, s1_rx_reg;
    logic [7:0] store_rd_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    logic       buf_ready;
    logic       exec_fire;
    result_t    res;

    // Architectural state
    phase_t     phase_reg, phase_next;
    logic [8:0] byte_index_reg, byte_index_next;
    logic [7:0] expected_reg, expected_next;
    logic [7:0] timeout_count_reg, timeout_count_next;
    logic [7:0] timeout_reload_reg;
    logic [QW-1:0] q_head_reg, q_head_next;
    logic [QC-1:0] q_count_reg, q_count_next;
    logic [SW-1:0] w_head_reg, w_head_next;
    logic [SC-1:0] w_count_reg, w_count_next;
    logic [SC-1:0] w_committed_reg, w_committed_next;
    logic [7:0] address_reg, address_next;

    logic [15:0] queue_mem [QUEUE_DEPTH];
    logic [7:0]  store_mem [WRITE_STORE_DEPTH];

    // Pipeline advances when the output buffer can take a word
    assign s_ready   = buf_ready;
    assign exec_fire = s1_valid_reg && buf_ready;
    assign cfg_ready = 1'b1;

    // Stage-one register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (buf_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_ready) begin
            s1_cmd_reg  <= s_cmd;
            s1_data_reg <= s_data_byte;
            s1_wl_reg   <= s_write_length;
            s1_rl_reg   <= s_read_length;
            s1_st_reg   <= s_bus_status;
            s1_rx_reg   <= s_received_byte;
        end
    end

    // Read address for the store: the byte the next status word would send.
    // Computed from the state as it will stand after the word now in stage two.
    logic [SW:0]   rd_sum;
    logic [SW-1:0] rd_addr;
    logic [SW:0]   wr_sum;
    logic [SW-1:0] wr_addr;
    logic          do_push;

    always_comb begin
        rd_sum = {1'b0, w_head_next} + (SW+1)'(byte_index_next[7:0]);
        if (rd_sum >= (SW+1)'(WRITE_STORE_DEPTH)) begin
            rd_sum = rd_sum - (SW+1)'(WRITE_STORE_DEPTH);
        end
        rd_addr = rd_sum[SW-1:0];
        wr_sum  = {1'b0, w_head_reg} + (SW+1)'(w_count_reg);
        if (wr_sum >= (SW+1)'(WRITE_STORE_DEPTH)) begin
            wr_sum = wr_sum - (SW+1)'(WRITE_STORE_DEPTH);
        end
        wr_addr = wr_sum[SW-1:0];
        do_push = exec_fire && (cmd_t'(s1_cmd_reg) == CMD_PUSH)
                  && (w_count_reg < SC'(WRITE_STORE_DEPTH));
    end

    // Write store memory, registered read with same-cycle write forwarding
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_mem[wr_addr] <= s1_data_reg;
        end
        if (exec_fire || !s1_valid_reg) begin
            store_rd_reg <= store_mem[rd_addr];
            fwd_hit_reg  <= do_push && (wr_addr == rd_addr);
            fwd_data_reg <= s1_data_reg;
        end
    end

    logic [7:0] store_byte;
    assign store_byte = fwd_hit_reg ? fwd_data_reg : store_rd_reg;

    // Transfer queue (small, head entry read combinationally from flops)
    logic [QC:0]   qt_sum;
    logic [QW-1:0] q_tail;
    logic          do_enq;
    always_comb begin
        qt_sum = {1'b0, QC'(q_head_reg)} + {1'b0, q_count_reg};
        if (qt_sum >= (QC+1)'(QUEUE_DEPTH)) begin
            qt_sum = qt_sum - (QC+1)'(QUEUE_DEPTH);
        end
        q_tail = qt_sum[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (do_enq) begin
            queue_mem[q_tail] <= {s1_rl_reg, s1_wl_reg};
        end
    end

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reload_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reload_reg <= cfg_data;
        end
    end

    // Execute stage
    logic [7:0] cur_wl, cur_rl;
    logic [SC-1:0] free_bytes;
    logic [8:0] got, left;
    logic do_finish, fin_err;
    logic [7:0] fin_status;
    logic [SW:0] wh_sum;
    logic [SC-1:0] wl_ext;

    always_comb begin
        cur_wl = queue_mem[q_head_reg][7:0];
        cur_rl = queue_mem[q_head_reg][15:8];
        wl_ext = (SC > 8) ? SC'(cur_wl) : SC'(cur_wl);
        free_bytes = w_count_reg - w_committed_reg;
        got = byte_index_reg - 9'd1;
        left = ({1'b0, cur_rl} > got) ? {1'b0, cur_rl} - got : 9'd0;

        res = '0;
        do_enq = 1'b0;
        do_finish = 1'b0;
        fin_err = 1'b0;
        fin_status = 8'd0;
        phase_next = phase_reg;
        byte_index_next = byte_index_reg;
        expected_next = expected_reg;
        timeout_count_next = timeout_count_reg;
        q_head_next = q_head_reg;
        q_count_next = q_count_reg;
        w_head_next = w_head_reg;
        w_count_next = w_count_reg;
        w_committed_next = w_committed_reg;
        address_next = address_reg;

        if (exec_fire) begin
            unique case (cmd_t'(s1_cmd_reg))
                CMD_PUSH: begin
                    if (w_count_reg < SC'(WRITE_STORE_DEPTH)) begin
                        w_count_next = w_count_reg + SC'(1);
                        res.accepted = 1'b1;
                    end
                end
                CMD_ENQUEUE: begin
                    if (s1_wl_reg >= 8'd2 && q_count_reg < QC'(QUEUE_DEPTH)
                        && {{(SC > 8 ? 0 : 8 - SC){1'b0}}, free_bytes} >= s1_wl_reg) begin
                        do_enq = 1'b1;
                        q_count_next = q_count_reg + QC'(1);
                        w_committed_next = w_committed_reg + SC'(s1_wl_reg);
                        res.accepted = 1'b1;
                        if (phase_reg == PH_IDLE) begin
                            phase_next = PH_WRITE;
                            byte_index_next = 9'd0;
                            res.bus_action = ACT_START;
                            expected_next = ST_START;
                            timeout_count_next = timeout_reload_reg;
                        end
                    end
                end
                CMD_STATUS: begin
                    timeout_count_next = timeout_reload_reg;
                    if (phase_reg != PH_IDLE) begin
                        if (s1_st_reg != expected_reg) begin
                            do_finish = 1'b1;
                            fin_err = 1'b1;
                            fin_status = s1_st_reg;
                        end else if (phase_reg == PH_WRITE) begin
                            if (byte_index_reg < {1'b0, cur_wl}) begin
                                if (byte_index_reg == 9'd0) begin
                                    address_next = store_byte;
                                end
                                res.transmit_valid = 1'b1;
                                res.transmit_byte = store_byte;
                                expected_next = (byte_index_reg == 9'd0) ?
                                                ST_MT_SLA_ACK : ST_MT_DATA_ACK;
                                byte_index_next = byte_index_reg + 9'd1;
                            end else if (cur_rl != 8'd0) begin
                                phase_next = PH_READ;
                                byte_index_next = 9'd0;
                                res.bus_action = ACT_START;
                                expected_next = ST_REP_START;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end else if (byte_index_reg == 9'd0) begin
                            res.transmit_valid = 1'b1;
                            res.transmit_byte = address_reg | 8'h01;
                            expected_next = ST_MR_SLA_ACK;
                            byte_index_next = 9'd1;
                        end else if (byte_index_reg == 9'd1) begin
                            if (cur_rl <= 8'd1) begin
                                expected_next = ST_MR_DATA_NACK;
                            end else begin
                                res.send_ack = 1'b1;
                                expected_next = ST_MR_DATA_ACK;
                            end
                            byte_index_next = 9'd2;
                        end else begin
                            res.read_valid = 1'b1;
                            res.read_byte = s1_rx_reg;
                            if (left == 9'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                if (left == 9'd1) begin
                                    expected_next = ST_MR_DATA_NACK;
                                end else begin
                                    res.send_ack = 1'b1;
                                    expected_next = ST_MR_DATA_ACK;
                                end
                                byte_index_next = byte_index_reg + 9'd1;
                            end
                        end
                    end
                end
                CMD_POLL: begin
                    if (phase_reg == PH_IDLE) begin
                        timeout_count_next = timeout_reload_reg;
                    end else if (timeout_count_reg == 8'd0) begin
                        do_finish = 1'b1;
                        fin_err = 1'b1;
                        timeout_count_next = timeout_reload_reg;
                    end else begin
                        timeout_count_next = timeout_count_reg - 8'd1;
                    end
                end
                default: ;
            endcase

            // Close the active transfer; a queued length never exceeds the store depth
            if (do_finish) begin
                res.transfer_done = 1'b1;
                res.transfer_error = fin_err;
                res.error_status = fin_status;
                wh_sum = {1'b0, w_head_reg} + (SW+1)'(cur_wl);
                if (wh_sum >= (SW+1)'(WRITE_STORE_DEPTH)) begin
                    wh_sum = wh_sum - (SW+1)'(WRITE_STORE_DEPTH);
                end
                w_head_next = wh_sum[SW-1:0];
                w_count_next = (w_count_reg >= wl_ext) ? w_count_reg - wl_ext : '0;
                w_committed_next = (w_committed_reg >= wl_ext) ?
                                   w_committed_reg - wl_ext : '0;
                q_head_next = (q_head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : q_head_reg + QW'(1);
                q_count_next = (q_count_reg != '0) ? q_count_reg - QC'(1) : '0;
                byte_index_next = 9'd0;
                if (q_count_next != '0) begin
                    phase_next = PH_WRITE;
                    res.bus_action = fin_err ? ACT_STOP_START : ACT_START;
                    expected_next = fin_err ? ST_START : ST_REP_START;
                end else begin
                    phase_next = PH_IDLE;
                    res.bus_action = ACT_STOP;
                    expected_next = ST_BUS_ERROR;
                end
            end else begin
                wh_sum = '0;
            end
            res.irq_enable = (phase_next != PH_IDLE);
            res.busy_res = (q_count_next != '0);
        end else begin
            wh_sum = '0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            byte_index_reg <= '0;
            expected_reg <= ST_BUS_ERROR;
            timeout_count_reg <= TIMEOUT_RESET;
            q_head_reg <= '0;
            q_count_reg <= '0;
            w_head_reg <= '0;
            w_count_reg <= '0;
            w_committed_reg <= '0;
            address_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            byte_index_reg <= byte_index_next;
            expected_reg <= expected_next;
            timeout_count_reg <= timeout_count_next;
            q_head_reg <= q_head_next;
            q_count_reg <= q_count_next;
            w_head_reg <= w_head_next;
            w_count_reg <= w_count_next;
            w_committed_reg <= w_committed_next;
            address_reg <= address_next;
        end
    end

    result_t out_word;

    i2cmts_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (exec_fire),
        .in_ready  (buf_ready),
        .in_word   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_accepted       = out_word.accepted;
    assign m_bus_action     = out_word.bus_action;
    assign m_send_ack       = out_word.send_ack;
    assign m_irq_enable     = out_word.irq_enable;
    assign m_transmit_valid = out_word.transmit_valid;
    assign m_transmit_byte  = out_word.transmit_byte;
    assign m_read_valid     = out_word.read_valid;
    assign m_read_byte      = out_word.read_byte;
    assign m_transfer_done  = out_word.transfer_done;
    assign m_transfer_error = out_word.transfer_error;
    assign m_error_status   = out_word.error_status;
    assign m_busy_res       = out_word.busy_res;

`ifndef SYNTH
    a_committed_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        w_committed_reg <= w_count_reg)
        else $error("committed bytes exceed stored bytes");
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (q_count_reg == '0))
        else $error("idle with queued transfer");
    a_active_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (q_count_reg != '0))
        else $error("active with empty queue");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import i2cmts_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int STORE_DEPTH = 64;
    localparam int XFER_DEPTH  = 4;

    // One word on the command channel
    typedef struct {
        cmd_t       cmd;
        logic [7:0] data;
        logic [7:0] wlen;
        logic [7:0] rlen;
        logic [7:0] status;
        logic [7:0] rx;
    } cmd_word_t;

    // Transfer sequencer predictor plus queue of expected result words
    class sequencer_scoreboard;
        logic [7:0] timeout_reload;
        phase_t     phase;
        int         step;
        logic [7:0] want_status;
        logic [7:0] ticks_left;
        logic [15:0] xfers [XFER_DEPTH];
        int         xfer_head, xfer_count;
        logic [7:0] bytes [STORE_DEPTH];
        int         byte_head, byte_count, byte_claimed;
        logic [7:0] addr;
        result_t    expected_words[$];
        int         fail_count;
        int         shown;
        bit         word_bad;

        function void clear();
            timeout_reload = 8'd255;
            phase          = PH_IDLE;
            step           = 0;
            want_status    = ST_BUS_ERROR;
            ticks_left     = 8'd255;
            xfer_head      = 0;
            xfer_count     = 0;
            byte_head      = 0;
            byte_count     = 0;
            byte_claimed   = 0;
            addr           = 8'h00;
            fail_count     = 0;
            shown          = 0;
        endfunction

        // close the head transfer and start the next queued one, or go idle if none is queued
        function void end_transfer(inout result_t r, input bit err, input logic [7:0] st);
            int wl;
            wl = xfers[xfer_head][7:0];
            r.transfer_done  = 1'b1;
            r.transfer_error = err;
            r.error_status   = err ? st : 8'h00;
            byte_head    = (byte_head + wl) % STORE_DEPTH;
            byte_count   = (byte_count >= wl) ? byte_count - wl : 0;
            byte_claimed = (byte_claimed >= wl) ? byte_claimed - wl : 0;
            xfer_head    = (xfer_head + 1) % XFER_DEPTH;
            xfer_count   = (xfer_count > 0) ? xfer_count - 1 : 0;
            step = 0;
            if (xfer_count != 0) begin
                phase = PH_WRITE;
                r.bus_action = err ? ACT_STOP_START : ACT_START;
                want_status  = err ? ST_START : ST_REP_START;
            end else begin
                phase = PH_IDLE;
                r.bus_action = ACT_STOP;
                want_status  = ST_BUS_ERROR;
            end
        endfunction

        // matching status: move the active transfer one step on
        function void step_transfer(inout result_t r, input logic [7:0] rx);
            int wl, rl, got, left;
            logic [7:0] b;
            wl = xfers[xfer_head][7:0];
            rl = xfers[xfer_head][15:8];
            if (phase == PH_WRITE) begin
                if (step < wl) begin
                    b = bytes[(byte_head + step) % STORE_DEPTH];
                    if (step == 0) addr = b;
                    r.transmit_valid = 1'b1;
                    r.transmit_byte  = b;
                    want_status = (step == 0) ? ST_MT_SLA_ACK : ST_MT_DATA_ACK;
                    step++;
                end else if (rl != 0) begin
                    phase = PH_READ;
                    step  = 0;
                    r.bus_action = ACT_START;
                    want_status  = ST_REP_START;
                end else begin
                    end_transfer(r, 1'b0, 8'h00);
                end
            end else if (step == 0) begin
                r.transmit_valid = 1'b1;
                r.transmit_byte  = addr | 8'h01;
                want_status = ST_MR_SLA_ACK;
                step = 1;
            end else if (step == 1) begin
                if (rl <= 1) begin
                    want_status = ST_MR_DATA_NACK;
                end else begin
                    r.send_ack  = 1'b1;
                    want_status = ST_MR_DATA_ACK;
                end
                step = 2;
            end else begin
                got  = step - 1;
                left = (rl > got) ? rl - got : 0;
                r.read_valid = 1'b1;
                r.read_byte  = rx;
                if (left == 0) begin
                    end_transfer(r, 1'b0, 8'h00);
                end else begin
                    if (left == 1) begin
                        want_status = ST_MR_DATA_NACK;
                    end else begin
                        r.send_ack  = 1'b1;
                        want_status = ST_MR_DATA_ACK;
                    end
                    step = (step + 1) & 9'h1FF;
                end
            end
        endfunction

        // accepted command word: predict its result word
        function void note_word(cmd_word_t w);
            result_t r;
            r = '0;
            case (w.cmd)
                CMD_PUSH: begin
                    if (byte_count < STORE_DEPTH) begin
                        bytes[(byte_head + byte_count) % STORE_DEPTH] = w.data;
                        byte_count++;
                        r.accepted = 1'b1;
                    end
                end
                CMD_ENQUEUE: begin
                    if (w.wlen >= 2 && xfer_count < XFER_DEPTH
                            && byte_count - byte_claimed >= w.wlen) begin
                        xfers[(xfer_head + xfer_count) % XFER_DEPTH] = {w.rlen, w.wlen};
                        xfer_count++;
                        byte_claimed += w.wlen;
                        r.accepted = 1'b1;
                        if (phase == PH_IDLE) begin
                            phase        = PH_WRITE;
                            step         = 0;
                            r.bus_action = ACT_START;
                            want_status  = ST_START;
                            ticks_left   = timeout_reload;
                        end
                    end
                end
                CMD_STATUS: begin
                    ticks_left = timeout_reload;
                    if (phase != PH_IDLE) begin
                        if (w.status == want_status) step_transfer(r, w.rx);
                        else end_transfer(r, 1'b1, w.status);
                    end
                end
                default: begin
                    if (phase == PH_IDLE) begin
                        ticks_left = timeout_reload;
                    end else if (ticks_left == 0) begin
                        end_transfer(r, 1'b1, 8'h00);
                        ticks_left = timeout_reload;
                    end else begin
                        ticks_left--;
                    end
                end
            endcase
            r.irq_enable = (phase != PH_IDLE);
            r.busy_res   = (xfer_count != 0);
            expected_words.push_back(r);
        endfunction

        function void cmp(string name, logic [7:0] e, logic [7:0] a);
            if (a !== e) begin
                word_bad = 1'b1;
                if (shown < 10) begin
                    $display("mismatch %s: expected %0h actual %0h", name, e, a);
                    shown++;
                end
            end
        endfunction

        // result word from the block: compare with the oldest prediction
        function void check_word(result_t a);
            result_t e;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (shown < 10) begin
                    $display("unexpected result word %h", a);
                    shown++;
                end
                return;
            end
            e = expected_words.pop_front();
            word_bad = 1'b0;
            cmp("accepted", e.accepted, a.accepted);
            cmp("bus_action", e.bus_action, a.bus_action);
            cmp("send_ack", e.send_ack, a.send_ack);
            cmp("irq_enable", e.irq_enable, a.irq_enable);
            cmp("transmit_valid", e.transmit_valid, a.transmit_valid);
            cmp("transmit_byte", e.transmit_byte, a.transmit_byte);
            cmp("read_valid", e.read_valid, a.read_valid);
            cmp("read_byte", e.read_byte, a.read_byte);
            cmp("transfer_done", e.transfer_done, a.transfer_done);
            cmp("transfer_error", e.transfer_error, a.transfer_error);
            cmp("error_status", e.error_status, a.error_status);
            cmp("busy_res", e.busy_res, a.busy_res);
            if (word_bad) fail_count++;
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd = CMD_POLL;
    logic [7:0] s_data_byte = 8'h00;
    logic [7:0] s_write_length = 8'h00;
    logic [7:0] s_read_length = 8'h00;
    logic [7:0] s_bus_status = 8'h00;
    logic [7:0] s_received_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    result_t    m_word;

    sequencer_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles = 0;

    always #4 aclk = ~aclk;

    i2c_master_transfer_sequencer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_data_byte     (s_data_byte),
        .s_write_length  (s_write_length),
        .s_read_length   (s_read_length),
        .s_bus_status    (s_bus_status),
        .s_received_byte (s_received_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_word.accepted),
        .m_bus_action    (m_word.bus_action),
        .m_send_ack      (m_word.send_ack),
        .m_irq_enable    (m_word.irq_enable),
        .m_transmit_valid(m_word.transmit_valid),
        .m_transmit_byte (m_word.transmit_byte),
        .m_read_valid    (m_word.read_valid),
        .m_read_byte     (m_word.read_byte),
        .m_transfer_done (m_word.transfer_done),
        .m_transfer_error(m_word.transfer_error),
        .m_error_status  (m_word.error_status),
        .m_busy_res      (m_word.busy_res)
    );

    // result side: random back-pressure, checking, stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_word(m_word);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(cmd_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= w.cmd;
        s_data_byte     <= w.data;
        s_write_length  <= w.wlen;
        s_read_length   <= w.rlen;
        s_bus_status    <= w.status;
        s_received_byte <= w.rx;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic write_timeout(logic [7:0] v);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.timeout_reload = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_word_t noise_word(cmd_t c);
        cmd_word_t w;
        w.cmd    = c;
        w.data   = 8'($urandom);
        w.wlen   = 8'($urandom);
        w.rlen   = 8'($urandom);
        w.status = 8'($urandom);
        w.rx     = 8'($urandom);
        return w;
    endfunction

    // pick the next word from the predicted state: mostly valid bus sequences
    function automatic cmd_word_t pick_word();
        cmd_word_t w;
        int roll, avail;
        roll  = $urandom_range(99);
        avail = sb.byte_count - sb.byte_claimed;
        if (sb.phase != PH_IDLE && roll < 72) begin
            w = noise_word(CMD_STATUS);
            if ($urandom_range(99) >= 4) w.status = sb.want_status;
        end else if ((sb.phase != PH_IDLE && roll < 80) || roll < 4) begin
            w = noise_word(CMD_POLL);
        end else if (sb.phase == PH_IDLE && roll < 8) begin
            w = noise_word(CMD_STATUS);
        end else if (avail >= 2 && $urandom_range(1)) begin
            w = noise_word(CMD_ENQUEUE);
            if ($urandom_range(99) >= 5) begin
                w.wlen = ($urandom_range(19) == 0) ? 8'($urandom_range(2, avail))
                       : 8'($urandom_range(2, (avail < 6) ? avail : 6));
                roll = $urandom_range(99);
                w.rlen = (roll < 60) ? 8'($urandom_range(0, 3))
                       : (roll < 98) ? 8'($urandom_range(4, 20)) : 8'd255;
            end
        end else begin
            w = noise_word(CMD_PUSH);
        end
        return w;
    endfunction

    initial begin
        cmd_word_t w;
        logic [7:0] reloads [4];
        int sent;
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reloads = '{8'd1, 8'd255, 8'd5, 8'd2};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle events, rejected enqueues, bus error, full store and queue
        send_word(noise_word(CMD_POLL));
        w = noise_word(CMD_STATUS); w.status = 8'hFF; w.rx = 8'hFF; send_word(w);
        w = noise_word(CMD_ENQUEUE); w.wlen = 8'hFF; w.rlen = 8'hFF; send_word(w);
        w = noise_word(CMD_ENQUEUE); w.wlen = 8'd1; w.rlen = 8'd0; send_word(w);
        w = noise_word(CMD_PUSH); w.data = 8'hFF; send_word(w);
        w = noise_word(CMD_PUSH); w.data = 8'h00; send_word(w);
        w = noise_word(CMD_ENQUEUE); w.wlen = 8'd2; w.rlen = 8'd1; send_word(w);
        w = noise_word(CMD_STATUS); w.status = ST_BUS_ERROR; send_word(w);
        for (int i = 0; i <= STORE_DEPTH; i++) begin
            w = noise_word(CMD_PUSH);
            send_word(w);
        end
        for (int i = 0; i <= XFER_DEPTH; i++) begin
            w = noise_word(CMD_ENQUEUE); w.wlen = 8'd2; w.rlen = 8'(i); send_word(w);
        end
        w = noise_word(CMD_STATUS); w.status = 8'hFF; send_word(w);

        // random phases, each with its own timeout setting; the first two also have their own idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            s_valid <= 1'b0;
            while (sb.expected_words.size() != 0) @(posedge aclk);
            write_timeout(reloads[ph]);
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 35 : 0;
            sent = 0;
            while (sent < 350) begin
                w = pick_word();
                if (!(sb.phase == PH_IDLE && (w.cmd == CMD_STATUS || w.cmd == CMD_POLL)))
                    sent++;
                send_word(w);
            end
        end
        s_valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
